// ----- design/mcm_pkg.sv -----
// mcm_pkg: shared types and constants of the metronome click mixer
// register indexes, configuration record, datapath command and status records
// no dependencies
package mcm_pkg;

    localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;
    localparam int DEFAULT_SAMPLE_BITS      = 24;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // multiplier operand width
    localparam int MULW  = 33;
    localparam int PRODW = 2 * MULW;

    localparam logic [31:0] Q30_ONE = 32'd1073741824;
    localparam logic [31:0] C_A1    = 32'd1686629713;
    localparam logic [31:0] C_A3    = 32'd693598669;
    localparam logic [31:0] C_A5    = 32'd85569306;
    localparam logic [31:0] C_A7    = 32'd5026995;
    localparam logic [31:0] C_A9    = 32'd172272;
    localparam logic [31:0] C_A11   = 32'd3863;

    // floor(w / 5) as (w * DIV5_RECIP) >> DIV5_SHIFT, exact below 2^34
    localparam int            DIV5_SHIFT = 35;
    localparam logic [MULW-1:0] DIV5_RECIP = 33'd6871947674;

    localparam logic [31:0] ENV_ONE = 32'd16777216;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_METRONOME_ENABLE,
        REG_BEATS_PER_BAR,
        REG_BEAT_INCREMENT,
        REG_CLICK_LENGTH,
        REG_CLICK_LENGTH_RECIP,
        REG_PHASE_STEP_DOWNBEAT,
        REG_PHASE_STEP_BEAT
    } reg_index_t;

    typedef struct packed {
        logic        metronome_enable;
        logic [6:0]  beats_per_bar;
        logic [31:0] beat_increment;
        logic [13:0] click_length;
        logic [24:0] click_length_recip;
        logic [30:0] phase_step_downbeat;
        logic [30:0] phase_step_beat;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_IDX,
        OP_TQ,
        OP_TR,
        OP_TDIV,
        OP_Z2,
        OP_H9,
        OP_H7,
        OP_H5,
        OP_H3,
        OP_H1,
        OP_SIN,
        OP_ENV,
        OP_ENV2,
        OP_MAG,
        OP_DIV5
    } op_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic wb;
        logic finish;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic click_active;
    } dp_status_t;

endpackage

// ----- design/mcm_in_if.sv -----
// mcm_in_if: input frame channel, one stereo sample with transport flags
// depends on mcm_pkg
interface mcm_in_if #(
    parameter int SAMPLE_BITS = mcm_pkg::DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          playing;
    logic                          rewind;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, playing, rewind, left_in, right_in, input ready);
    modport sink (input valid, playing, rewind, left_in, right_in, output ready);
endinterface

// ----- design/mcm_out_if.sv -----
// mcm_out_if: result channel, mixed stereo sample and click flags
// depends on mcm_pkg
interface mcm_out_if #(
    parameter int SAMPLE_BITS = mcm_pkg::DEFAULT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          click_start;
    logic                          downbeat;

    modport source (output valid, left_out, right_out, click_start, downbeat, input ready);
    modport sink (input valid, left_out, right_out, click_start, downbeat, output ready);
endinterface

// ----- design/mcm_cfg_if.sv -----
// mcm_cfg_if: configuration write channel, register index and data
// depends on mcm_pkg
interface mcm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mcm_pkg::CFG_INDEX_BITS-1:0] index;
    logic [mcm_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/mcm_cfg.sv -----
// mcm_cfg: configuration register file of the metronome click mixer
// depends on mcm_pkg and mcm_cfg_if
module mcm_cfg (
    input  logic            clk,
    input  logic            rst_n,
    mcm_cfg_if.sink         cfg,
    output mcm_pkg::cfg_t   regs
);
    import mcm_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.metronome_enable    <= 1'b0;
            regs_reg.beats_per_bar       <= 7'd4;
            regs_reg.beat_increment      <= 32'd178957;
            regs_reg.click_length        <= 14'd1440;
            regs_reg.click_length_recip  <= 25'd11650;
            regs_reg.phase_step_downbeat <= 31'd140302264;
            regs_reg.phase_step_beat     <= 31'd93639235;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_METRONOME_ENABLE:    regs_reg.metronome_enable    <= cfg.data[0];
                REG_BEATS_PER_BAR:       regs_reg.beats_per_bar       <= cfg.data[6:0];
                REG_BEAT_INCREMENT:      regs_reg.beat_increment      <= cfg.data[31:0];
                REG_CLICK_LENGTH:        regs_reg.click_length        <= cfg.data[13:0];
                REG_CLICK_LENGTH_RECIP:  regs_reg.click_length_recip  <= cfg.data[24:0];
                REG_PHASE_STEP_DOWNBEAT: regs_reg.phase_step_downbeat <= cfg.data[30:0];
                REG_PHASE_STEP_BEAT:     regs_reg.phase_step_beat     <= cfg.data[30:0];
                default:                 regs_reg                     <= regs_reg;
            endcase
        end
    end

endmodule

// ----- design/mcm_dp.sv -----
// mcm_dp: datapath, beat tracking, shared 33x33 multiplier, sine polynomial,
// envelope, click scaling and saturating mix; depends on mcm_pkg
module mcm_dp #(
    parameter int SINE_TABLE_DEPTH = mcm_pkg::DEFAULT_SINE_TABLE_DEPTH,
    parameter int SAMPLE_BITS      = mcm_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcm_pkg::dp_cmd_t              cmd,
    output mcm_pkg::dp_status_t           status,
    input  mcm_pkg::cfg_t                 regs,
    input  logic                          playing,
    input  logic                          rewind,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic                          click_start,
    output logic                          downbeat
);
    import mcm_pkg::*;

    localparam int IDXW = $clog2(SINE_TABLE_DEPTH);
    localparam int N2W  = 2 * IDXW;
    localparam longint TQ  = (longint'(1) << 32) / SINE_TABLE_DEPTH;
    localparam longint TR  = (longint'(1) << 32) % SINE_TABLE_DEPTH;
    localparam int     RSH = 3 * IDXW + 1;
    localparam longint RM  = ((longint'(1) << RSH) + SINE_TABLE_DEPTH - 1) / SINE_TABLE_DEPTH;
    localparam int UPSH = (SAMPLE_BITS >= 30) ? SAMPLE_BITS - 30 : 0;
    localparam int DNSH = (SAMPLE_BITS >= 30) ? 0 : 30 - SAMPLE_BITS;
    localparam int MAGW = SAMPLE_BITS - 1;
    localparam logic signed [SAMPLE_BITS+1:0] SAT_HI = $signed({3'b000, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SAMPLE_BITS+1:0] SAT_LO = $signed({3'b111, {(SAMPLE_BITS-1){1'b0}}});

    function automatic logic signed [33:0] horner_coef(input op_t op);
        case (op)
            OP_H9:   return $signed({2'b00, C_A9});
            OP_H7:   return -$signed({2'b00, C_A7});
            OP_H5:   return $signed({2'b00, C_A5});
            OP_H3:   return -$signed({2'b00, C_A3});
            OP_H1:   return $signed({2'b00, C_A1});
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [SAMPLE_BITS+1:0] v
    );
        if (v > SAT_HI)
            return SAT_HI[SAMPLE_BITS-1:0];
        else if (v < SAT_LO)
            return SAT_LO[SAMPLE_BITS-1:0];
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    // frame state
    logic [47:0] pos_reg;
    logic [6:0]  bar_reg;
    logic [13:0] samples_reg;
    logic [31:0] phase_reg;
    logic [31:0] step_reg;

    // working registers
    logic                          started_reg;
    logic                          down_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic [PRODW-1:0]              prod_reg;
    logic [IDXW-1:0]               idx_reg;
    logic [31:0]                   t_reg;
    logic [N2W-1:0]                n2_reg;
    logic [1:0]                    quad_reg;
    logic [30:0]                   z_reg;
    logic [30:0]                   z2_reg;
    logic [31:0]                   acc_mag_reg;
    logic                          acc_neg_reg;
    logic [30:0]                   as_reg;
    logic [24:0]                   env_reg;
    logic [24:0]                   env2_reg;
    logic [30:0]                   m_reg;
    logic [MAGW-1:0]               mag_reg;

    // result registers
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic                          click_start_reg;
    logic                          downbeat_reg;

    // beat tracking
    logic [47:0] pos0;
    logic [6:0]  bar0;
    logic [47:0] pos_adv;
    logic        crossing;
    logic [6:0]  bar_eff;
    logic [7:0]  bar_inc;
    logic [6:0]  bar1;
    logic        wanted;
    logic        started;
    logic        down;

    always_comb
    begin
        pos0     = rewind ? '0 : pos_reg;
        bar0     = rewind ? '0 : bar_reg;
        pos_adv  = pos0 + 48'(regs.beat_increment);
        crossing = playing && (pos_adv[47:32] != pos0[47:32]);
        bar_eff  = (regs.beats_per_bar == '0) ? 7'd1 : regs.beats_per_bar;
        bar_inc  = {1'b0, bar0} + 8'd1;
        if (crossing)
            bar1 = (bar_inc >= {1'b0, bar_eff}) ? '0 : bar_inc[6:0];
        else
            bar1 = bar0;
        wanted  = playing && regs.metronome_enable;
        started = wanted && (crossing || (pos0 == '0));
        down    = (bar1 == '0);
    end

    // multiplier operands
    logic [MULW-1:0]  mul_a;
    logic [MULW-1:0]  mul_b;
    logic [PRODW-1:0] prod_full;
    logic [MULW-1:0]  div5_in;

    assign div5_in = (MULW'(m_reg) << UPSH) >> DNSH;

    always_comb
    begin
        case (cmd.op)
            OP_IDX:
            begin
                mul_a = MULW'(phase_reg);
                mul_b = MULW'(SINE_TABLE_DEPTH);
            end
            OP_TQ:
            begin
                mul_a = MULW'(idx_reg);
                mul_b = MULW'(TQ);
            end
            OP_TR:
            begin
                mul_a = MULW'(idx_reg);
                mul_b = MULW'(TR);
            end
            OP_TDIV:
            begin
                mul_a = MULW'(n2_reg);
                mul_b = MULW'(RM);
            end
            OP_Z2:
            begin
                mul_a = MULW'(z_reg);
                mul_b = MULW'(z_reg);
            end
            OP_H9, OP_H7, OP_H5, OP_H3, OP_H1:
            begin
                mul_a = MULW'(acc_mag_reg);
                mul_b = MULW'(z2_reg);
            end
            OP_SIN:
            begin
                mul_a = MULW'(acc_mag_reg);
                mul_b = MULW'(z_reg);
            end
            OP_ENV:
            begin
                mul_a = MULW'(samples_reg);
                mul_b = MULW'(regs.click_length_recip);
            end
            OP_ENV2:
            begin
                mul_a = MULW'(env_reg);
                mul_b = MULW'(env_reg);
            end
            OP_MAG:
            begin
                mul_a = MULW'(as_reg);
                mul_b = MULW'(env2_reg);
            end
            OP_DIV5:
            begin
                mul_a = div5_in;
                mul_b = DIV5_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // write-back helpers
    logic [31:0]        t_sum;
    logic [31:0]        prod_q30;
    logic signed [33:0] horner_term;
    logic signed [33:0] horner_sum;
    logic signed [33:0] horner_abs;

    always_comb
    begin
        t_sum       = t_reg + 32'(prod_reg[RSH +: IDXW]);
        prod_q30    = prod_reg[30 +: 32];
        horner_term = acc_neg_reg ? -$signed({2'b00, prod_q30}) : $signed({2'b00, prod_q30});
        horner_sum  = horner_coef(cmd.op) + horner_term;
        horner_abs  = horner_sum[33] ? -horner_sum : horner_sum;
    end

    // mix
    logic                          click_active;
    logic signed [SAMPLE_BITS-1:0] click_mag;
    logic signed [SAMPLE_BITS-1:0] click_val;
    logic signed [SAMPLE_BITS+1:0] left_sum;
    logic signed [SAMPLE_BITS+1:0] right_sum;

    always_comb
    begin
        click_active = (samples_reg != '0);
        click_mag    = $signed({1'b0, mag_reg});
        if (!click_active)
            click_val = '0;
        else if (quad_reg[1])
            click_val = -click_mag;
        else
            click_val = click_mag;
        left_sum  = (SAMPLE_BITS+2)'(left_reg) + (SAMPLE_BITS+2)'(click_val);
        right_sum = (SAMPLE_BITS+2)'(right_reg) + (SAMPLE_BITS+2)'(click_val);
    end

    assign status.click_active = click_active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            bar_reg     <= '0;
            samples_reg <= '0;
            phase_reg   <= '0;
            step_reg    <= '0;
        end
        else if (cmd.load)
        begin
            pos_reg <= playing ? pos_adv : pos0;
            bar_reg <= bar1;
            if (started)
            begin
                samples_reg <= regs.click_length;
                phase_reg   <= '0;
                step_reg    <= {1'b0, down ? regs.phase_step_downbeat : regs.phase_step_beat};
            end
        end
        else if (cmd.finish && click_active)
        begin
            phase_reg   <= phase_reg + step_reg;
            samples_reg <= samples_reg - 14'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            started_reg <= started;
            down_reg    <= started && down;
            left_reg    <= left_in;
            right_reg   <= right_in;
        end
        if (cmd.mul)
            prod_reg <= prod_full;
        if (cmd.wb)
        begin
            case (cmd.op)
                OP_IDX:  idx_reg <= prod_reg[32 +: IDXW];
                OP_TQ:   t_reg   <= prod_reg[31:0];
                OP_TR:   n2_reg  <= prod_reg[N2W-1:0];
                OP_TDIV:
                begin
                    quad_reg    <= t_sum[31:30];
                    z_reg       <= t_sum[30] ? (Q30_ONE[30:0] - {1'b0, t_sum[29:0]})
                                             : {1'b0, t_sum[29:0]};
                    acc_mag_reg <= C_A11;
                    acc_neg_reg <= 1'b1;
                end
                OP_Z2:   z2_reg <= prod_reg[30 +: 31];
                OP_H9, OP_H7, OP_H5, OP_H3, OP_H1:
                begin
                    acc_mag_reg <= horner_abs[31:0];
                    acc_neg_reg <= horner_sum[33];
                end
                OP_SIN:
                begin
                    if (acc_neg_reg)
                        as_reg <= '0;
                    else if (prod_q30 > Q30_ONE)
                        as_reg <= Q30_ONE[30:0];
                    else
                        as_reg <= prod_q30[30:0];
                end
                OP_ENV:
                begin
                    if (prod_reg > PRODW'(ENV_ONE))
                        env_reg <= ENV_ONE[24:0];
                    else
                        env_reg <= prod_reg[24:0];
                end
                OP_ENV2: env2_reg <= prod_reg[24 +: 25];
                OP_MAG:  m_reg    <= prod_reg[24 +: 31];
                OP_DIV5: mag_reg  <= prod_reg[DIV5_SHIFT +: MAGW];
                default: mag_reg  <= mag_reg;
            endcase
        end
        if (cmd.finish)
        begin
            left_out_reg    <= saturate(left_sum);
            right_out_reg   <= saturate(right_sum);
            click_start_reg <= started_reg;
            downbeat_reg    <= down_reg;
        end
    end

    assign left_out    = left_out_reg;
    assign right_out   = right_out_reg;
    assign click_start = click_start_reg;
    assign downbeat    = downbeat_reg;

endmodule

// ----- design/mcm_ctrl.sv -----
// mcm_ctrl: controller, sequences load, multiply, write-back and mix steps and
// holds the result valid flag; depends on mcm_pkg
module mcm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    output logic                frame_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  mcm_pkg::dp_status_t status,
    output mcm_pkg::dp_cmd_t    cmd
);
    import mcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_WB,
        S_MIX
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'd14;

    function automatic op_t op_at(input logic [3:0] step);
        case (step)
            4'd0:    return OP_IDX;
            4'd1:    return OP_TQ;
            4'd2:    return OP_TR;
            4'd3:    return OP_TDIV;
            4'd4:    return OP_Z2;
            4'd5:    return OP_H9;
            4'd6:    return OP_H7;
            4'd7:    return OP_H5;
            4'd8:    return OP_H3;
            4'd9:    return OP_H1;
            4'd10:   return OP_SIN;
            4'd11:   return OP_ENV;
            4'd12:   return OP_ENV2;
            4'd13:   return OP_MAG;
            default: return OP_DIV5;
        endcase
    endfunction

    state_t     state_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free     = !out_valid_reg || result_ready;
    assign frame_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && frame_valid;
        cmd.mul    = (state_reg == S_MUL);
        cmd.wb     = (state_reg == S_WB);
        cmd.finish = (state_reg == S_MIX) && out_free;
        cmd.op     = op_at(step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (frame_valid)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    step_reg  <= '0;
                    state_reg <= status.click_active ? S_MUL : S_MIX;
                end
                S_MUL:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (step_reg == LAST_STEP)
                        state_reg <= S_MIX;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_MIX:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/metronome_click_mixer_unit.sv -----
// metronome_click_mixer_unit: one frame at a time; while a click sounds a frame takes
// 15 products on the one shared multiplier, each a multiply step then a write-back step,
// and none when no click sounds; the next frame is accepted in the cycle after the result
// is written, and a finished result waits in the output register meanwhile
// rst_n clears beat position, bar count, click state and configuration registers to their defaults
// depends on mcm_pkg, mcm_in_if, mcm_out_if, mcm_cfg_if, mcm_cfg, mcm_ctrl, mcm_dp
module metronome_click_mixer_unit #(
    parameter int SINE_TABLE_DEPTH = mcm_pkg::DEFAULT_SINE_TABLE_DEPTH,
    parameter int SAMPLE_BITS      = mcm_pkg::DEFAULT_SAMPLE_BITS
) (
    input logic       clk,
    input logic       rst_n,
    mcm_in_if.sink    frame,
    mcm_out_if.source result,
    mcm_cfg_if.sink   cfg
);
    import mcm_pkg::*;

    cfg_t       regs;
    dp_cmd_t    cmd;
    dp_status_t status;

    mcm_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mcm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    mcm_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .regs        (regs),
        .playing     (frame.playing),
        .rewind      (frame.rewind),
        .left_in     (frame.left_in),
        .right_in    (frame.right_in),
        .left_out    (result.left_out),
        .right_out   (result.right_out),
        .click_start (result.click_start),
        .downbeat    (result.downbeat)
    );

endmodule
